>>> sv/bmds_pkg.sv
// shared constants for the binary matrix diffusion and word shuffle block
package bmds_pkg;

    localparam int GROUP_WORDS_DEF = 4;
    localparam int STATE_WORDS_DEF = 16;
    localparam int WORD_BITS_DEF   = 8;

    localparam int HALF_W   = 64;
    localparam int PORT_W   = 2 * HALF_W;
    localparam int ACTION_W = 2;
    localparam int MATRIX_W = 16;
    localparam int SHUF_W   = 64;
    localparam int NIB_W    = 4;
    localparam int SHUF_WORDS = SHUF_W / NIB_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [ACTION_W-1:0] ACT_FORWARD       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INVERSE       = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INV_TRANSPOSE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TRANSPOSE     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TRANSPOSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE       = 3'd4;

    localparam logic [MATRIX_W-1:0] MATRIX_RESET  = 16'h8421;
    localparam logic [SHUF_W-1:0]   SHUFFLE_RESET = 64'hFEDC_BA98_7654_3210;

endpackage

>>> sv/bmds_lane.sv
// one column lane: binary matrix times a column of words over xor
module bmds_lane
    import bmds_pkg::*;
#(
    parameter int GROUP_WORDS = GROUP_WORDS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic [MATRIX_W-1:0]                    i_matrix,
    input  logic [GROUP_WORDS-1:0][WORD_BITS-1:0]  i_words,
    output logic [GROUP_WORDS-1:0][WORD_BITS-1:0]  o_words
);

    localparam int SQ_W  = GROUP_WORDS * GROUP_WORDS;
    localparam int MAT_W = (SQ_W > MATRIX_W) ? SQ_W : MATRIX_W;

    logic [MAT_W-1:0] mat_ext;

    assign mat_ext = MAT_W'(i_matrix);

    always_comb begin
        for (int r = 0; r < GROUP_WORDS; r++) begin
            o_words[r] = '0;
            for (int j = 0; j < GROUP_WORDS; j++) begin
                if (mat_ext[r * GROUP_WORDS + j]) begin
                    o_words[r] = o_words[r] ^ i_words[j];
                end
            end
        end
    end

endmodule

>>> sv/bmds_perm.sv
// word shuffle network: gather through the table (word o takes word dest[o]) and scatter through the table
module bmds_perm
    import bmds_pkg::*;
#(
    parameter int STATE_WORDS = STATE_WORDS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic [SHUF_W-1:0]                      i_shuffle,
    input  logic [STATE_WORDS-1:0][WORD_BITS-1:0]  i_gather_words,
    output logic [STATE_WORDS-1:0][WORD_BITS-1:0]  o_gather_words,
    input  logic [STATE_WORDS-1:0][WORD_BITS-1:0]  i_scatter_words,
    output logic [STATE_WORDS-1:0][WORD_BITS-1:0]  o_scatter_words
);

    localparam int IDX_W  = (STATE_WORDS > 1) ? $clog2(STATE_WORDS) : 1;
    localparam int DEST_W = (IDX_W > NIB_W) ? IDX_W : NIB_W;

    logic [DEST_W-1:0]      dest [STATE_WORDS];
    logic [STATE_WORDS-1:0] first_use;
    logic [STATE_WORDS-1:0] last_use;

    for (genvar w = 0; w < STATE_WORDS; w++) begin : g_dest
        if (w < SHUF_WORDS) begin : g_tab
            assign dest[w] = DEST_W'(i_shuffle[NIB_W * w +: NIB_W]);
        end else begin : g_self
            assign dest[w] = DEST_W'(w);
        end
    end

    always_comb begin
        for (int o = 0; o < STATE_WORDS; o++) begin
            first_use[o] = 1'b1;
            last_use[o]  = 1'b1;
            for (int p = 0; p < STATE_WORDS; p++) begin
                if (p < o && dest[p] == dest[o]) begin
                    first_use[o] = 1'b0;
                end
                if (p > o && dest[p] == dest[o]) begin
                    last_use[o] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int o = 0; o < STATE_WORDS; o++) begin
            o_gather_words[o] = '0;
            for (int s = 0; s < STATE_WORDS; s++) begin
                if (first_use[o] && dest[o] == DEST_W'(s)) begin
                    o_gather_words[o] = i_gather_words[s];
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < STATE_WORDS; d++) begin
            o_scatter_words[d] = '0;
            for (int w = 0; w < STATE_WORDS; w++) begin
                if (last_use[w] && dest[w] == DEST_W'(d)) begin
                    o_scatter_words[d] = o_scatter_words[d] | i_scatter_words[w];
                end
            end
        end
    end

endmodule

>>> sv/binary_matrix_diffusion_shuffle_top.sv
// top level of the binary matrix diffusion layer with word shuffle
//
// Input channel: a state of 16 words on i_state_low / i_state_high plus
// i_action is transferred at a rising edge with i_start high and o_busy low.
// o_busy stays low: a new state can be started every cycle.
// Result channel: o_valid is high for exactly one cycle with the diffused
// state on o_result_low / o_result_high; the receiver takes it in that cycle
// and cannot stall, so no backpressure exists anywhere in the block.
// Stages: a start transfer is registered in stage A, then in stage B, which drives o_valid.
// Throughput: one state per cycle, set by the two-stage lane pipeline; the
// first stage multiplies (forward, inverse transpose) or gathers (inverse,
// transpose), the second stage scatters or multiplies.
// Configuration: writes on i_cfg_valid / o_cfg_ready (always ready) with a
// register index and data; index 0..3 select the four 16-bit matrices, index
// 4 the 64-bit shuffle table; other indexes are ignored. Write only while idle.
// Reset: i_rst_n low synchronously clears the pipeline valids and loads the
// identity matrices and identity shuffle table.
module binary_matrix_diffusion_shuffle_top
    import bmds_pkg::*;
#(
    parameter int GROUP_WORDS = GROUP_WORDS_DEF,
    parameter int STATE_WORDS = STATE_WORDS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [HALF_W-1:0]     i_state_low,
    input  logic [HALF_W-1:0]     i_state_high,
    output logic                  o_valid,
    output logic [HALF_W-1:0]     o_result_low,
    output logic [HALF_W-1:0]     o_result_high,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int STATE_BITS = STATE_WORDS * WORD_BITS;
    localparam int COLS       = STATE_WORDS / GROUP_WORDS;
    localparam int COL_WORDS  = COLS * GROUP_WORDS;

    logic [MATRIX_W-1:0] r_fwd_mat;
    logic [MATRIX_W-1:0] r_inv_mat;
    logic [MATRIX_W-1:0] r_invt_mat;
    logic [MATRIX_W-1:0] r_tr_mat;
    logic [SHUF_W-1:0]   r_shuffle;

    logic [STATE_BITS-1:0]                  in_flat;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  in_words;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  mul_a;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  gath_a;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  mul_b;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  scat_b;
    logic [MATRIX_W-1:0]                    mat_a;
    logic [MATRIX_W-1:0]                    mat_b;
    logic                                   accept;
    logic                                   mul_first_a;
    logic                                   mul_first_b;

    logic                                   r_a_valid;
    logic [ACTION_W-1:0]                    r_a_action;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  r_a_words;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  n_a_words;
    logic                                   r_b_valid;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  r_b_words;
    logic [STATE_WORDS-1:0][WORD_BITS-1:0]  n_b_words;
    logic [PORT_W-1:0]                      out_flat;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_mat  <= MATRIX_RESET;
            r_inv_mat  <= MATRIX_RESET;
            r_invt_mat <= MATRIX_RESET;
            r_tr_mat   <= MATRIX_RESET;
            r_shuffle  <= SHUFFLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FORWARD:       r_fwd_mat  <= i_cfg_data[MATRIX_W-1:0];
                CFG_INVERSE:       r_inv_mat  <= i_cfg_data[MATRIX_W-1:0];
                CFG_INV_TRANSPOSE: r_invt_mat <= i_cfg_data[MATRIX_W-1:0];
                CFG_TRANSPOSE:     r_tr_mat   <= i_cfg_data[MATRIX_W-1:0];
                CFG_SHUFFLE:       r_shuffle  <= i_cfg_data[SHUF_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_flat  = STATE_BITS'({i_state_high, i_state_low});
    assign in_words = in_flat;

    always_comb begin
        mul_first_a = i_action inside {ACT_FORWARD, ACT_INV_TRANSPOSE};
        mul_first_b = r_a_action inside {ACT_FORWARD, ACT_INV_TRANSPOSE};
        case (i_action)
            ACT_FORWARD:       mat_a = r_fwd_mat;
            ACT_INV_TRANSPOSE: mat_a = r_invt_mat;
            default:           mat_a = '0;
        endcase
        case (r_a_action)
            ACT_INVERSE:   mat_b = r_inv_mat;
            ACT_TRANSPOSE: mat_b = r_tr_mat;
            default:       mat_b = '0;
        endcase
    end

    for (genvar c = 0; c < COLS; c++) begin : g_lane
        bmds_lane #(
            .GROUP_WORDS (GROUP_WORDS),
            .WORD_BITS   (WORD_BITS)
        ) u_lane_a (
            .i_matrix (mat_a),
            .i_words  (in_words[c * GROUP_WORDS +: GROUP_WORDS]),
            .o_words  (mul_a[c * GROUP_WORDS +: GROUP_WORDS])
        );
        bmds_lane #(
            .GROUP_WORDS (GROUP_WORDS),
            .WORD_BITS   (WORD_BITS)
        ) u_lane_b (
            .i_matrix (mat_b),
            .i_words  (r_a_words[c * GROUP_WORDS +: GROUP_WORDS]),
            .o_words  (mul_b[c * GROUP_WORDS +: GROUP_WORDS])
        );
    end

    if (COL_WORDS < STATE_WORDS) begin : g_tail
        assign mul_a[STATE_WORDS-1:COL_WORDS] = '0;
        assign mul_b[STATE_WORDS-1:COL_WORDS] = '0;
    end

    bmds_perm #(
        .STATE_WORDS (STATE_WORDS),
        .WORD_BITS   (WORD_BITS)
    ) u_perm (
        .i_shuffle       (r_shuffle),
        .i_gather_words  (in_words),
        .o_gather_words  (gath_a),
        .i_scatter_words (r_a_words),
        .o_scatter_words (scat_b)
    );

    assign n_a_words = mul_first_a ? mul_a : gath_a;
    assign n_b_words = mul_first_b ? scat_b : mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_action <= i_action;
            r_a_words  <= n_a_words;
        end
        if (r_a_valid) begin
            r_b_words <= n_b_words;
        end
    end

    assign out_flat      = PORT_W'(r_b_words);
    assign o_valid       = r_b_valid;
    assign o_result_low  = out_flat[HALF_W-1:0];
    assign o_result_high = out_flat[PORT_W-1:HALF_W];

endmodule

>>> sv/bmds_checker.sv
// port-level checker for the diffusion block, bound to the top level
module bmds_checker
    import bmds_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // every start transfer is followed by a result on o_valid
    a_start_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("missing result after start transfer");

    // no result without an earlier start transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without start transfer");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // the block never refuses a start
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

endmodule

bind binary_matrix_diffusion_shuffle_top bmds_checker u_bmds_checker (.*);
